/* rtl/rgb_rank_order_window_filter_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the RGB rank-order window filter
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_RANK_ORDER_WINDOW_FILTER_UNIT_DEFINES_SVH
`define RGB_RANK_ORDER_WINDOW_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define RROF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RROF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rrof_pkg.sv */
// ----------------------------------------------------------------------------
// rrof_pkg
// Shared sizes, codes and control bundles of the rank-order window filter.
// ----------------------------------------------------------------------------
package rrof_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_WINDOW = 7;

  localparam int PIX_W   = 8;
  localparam int CH_N    = 3;
  localparam int RGB_W   = CH_N * PIX_W;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WD_W    = COL_W + 1;
  localparam int HT_W    = ROW_W + 1;
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SUM_W   = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int SLOT_W  = $clog2(MAX_WINDOW);
  localparam int MEM_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int XY_W    = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
  localparam int BIT_W   = $clog2(PIX_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int OUT_DATA_W  = RGB_W + ROW_W + COL_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    MODE_MIN    = 3'd0,
    MODE_MAX    = 3'd1,
    MODE_MEDIAN = 3'd2,
    MODE_MEAN   = 3'd3,
    MODE_CLEAN  = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_WINDOW    = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_WIDTH     = 3'd3,
    CFG_HEIGHT    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CENTRE,
    ST_PASS,
    ST_DRAIN,
    ST_DLOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  // saturated configuration as seen by the datapath
  typedef struct packed {
    logic [2:0]       mode;
    logic [WIN_W-1:0] win;
    logic [WD_W-1:0]  width;
    logic [HT_W-1:0]  height;
    logic [PIX_W-1:0] thr;
    logic [CNT_W-1:0] n;
  } cfg_t;

  // tag travelling with each read beat of the line store
  typedef struct packed {
    logic             smp;
    logic             first;
    logic             last;
    logic             is_ctr;
    logic             stats;
    logic [BIT_W-1:0] bitpos;
  } smp_tag_t;

  typedef struct packed {
    smp_tag_t         tag;
    logic             div_ld;
    logic             div_step;
    logic [BIT_W-1:0] dbit;
  } lane_ctl_t;

  typedef struct packed {
    logic             load;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             eof;
  } emit_t;

endpackage

/* rtl/rrof_lane.sv */
// ----------------------------------------------------------------------------
// rrof_lane
// One color channel: min/max/sum over the window, radix select of the two
// middle ranks for the median, and a bit-serial divide for the mean.
// ----------------------------------------------------------------------------
module rrof_lane import rrof_pkg::*; (
  input  logic             clk,
  input  cfg_t             cfg,
  input  lane_ctl_t        ctl,
  input  logic [PIX_W-1:0] pix,
  output logic [PIX_W-1:0] res
);

  logic [PIX_W-1:0] mn, mx, ctr_v, pre_a, pre_b, quo;
  logic [SUM_W-1:0] sum, rem;
  logic [CNT_W-1:0] ka, kb, cnt_a, cnt_b;

  logic [PIX_W-1:0] hi_mask, one_b, med, dev;
  logic             hit_a, hit_b;
  logic [CNT_W-1:0] cnt_a_now, cnt_b_now;
  logic [SUM_W-1:0] dv;
  logic [PIX_W:0]   pair;

  always_comb begin
    for (int q = 0; q < PIX_W; q++) begin
      hi_mask[q] = (q > int'(ctl.tag.bitpos));
    end
    one_b     = PIX_W'(1) << ctl.tag.bitpos;
    hit_a     = ((pix & hi_mask) == pre_a) && !pix[ctl.tag.bitpos];
    hit_b     = ((pix & hi_mask) == pre_b) && !pix[ctl.tag.bitpos];
    cnt_a_now = (ctl.tag.first ? '0 : cnt_a) + CNT_W'(hit_a);
    cnt_b_now = (ctl.tag.first ? '0 : cnt_b) + CNT_W'(hit_b);
    dv        = SUM_W'(cfg.n) << ctl.dbit;
  end

  always_ff @(posedge clk) begin
    if (ctl.tag.smp && ctl.tag.is_ctr) begin
      ctr_v <= pix;
    end
    if (ctl.tag.smp && ctl.tag.stats) begin
      if (ctl.tag.first) begin
        mn    <= pix;
        mx    <= pix;
        sum   <= SUM_W'(pix);
        pre_a <= '0;
        pre_b <= '0;
        ka    <= (cfg.n - CNT_W'(1)) >> 1;
        kb    <= cfg.n >> 1;
      end else begin
        if (pix < mn) mn <= pix;
        if (pix > mx) mx <= pix;
        sum <= sum + SUM_W'(pix);
      end
    end
    // radix pass: count smaller candidates, then fix one bit of each rank
    if (ctl.tag.smp && !ctl.tag.stats && !ctl.tag.is_ctr) begin
      cnt_a <= cnt_a_now;
      cnt_b <= cnt_b_now;
      if (ctl.tag.last) begin
        if (ka >= cnt_a_now) begin
          pre_a <= pre_a | one_b;
          ka    <= ka - cnt_a_now;
        end
        if (kb >= cnt_b_now) begin
          pre_b <= pre_b | one_b;
          kb    <= kb - cnt_b_now;
        end
      end
    end
    if (ctl.div_ld) begin
      rem <= sum;
      quo <= '0;
    end else if (ctl.div_step) begin
      if (rem >= dv) begin
        rem           <= rem - dv;
        quo[ctl.dbit] <= 1'b1;
      end
    end
  end

  always_comb begin
    pair = ({1'b0, pre_a} + {1'b0, pre_b}) >> 1;
    med  = pair[PIX_W-1:0];
    dev  = (quo > ctr_v) ? (quo - ctr_v) : (ctr_v - quo);
    unique case (cfg.mode)
      MODE_MIN:    res = mn;
      MODE_MAX:    res = mx;
      MODE_MEDIAN: res = med;
      MODE_MEAN:   res = quo;
      MODE_CLEAN:  res = (dev > cfg.thr) ? quo : ctr_v;
      default:     res = ctr_v;
    endcase
  end

endmodule

/* rtl/rrof_ctrl.sv */
// ----------------------------------------------------------------------------
// rrof_ctrl
// Line store, raster position tracking and the window walk sequencer that
// feeds the channel lanes one window element per cycle.
// ----------------------------------------------------------------------------
module rrof_ctrl import rrof_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RGB_W-1:0] in_pix,
  input  logic             out_free,
  output logic [RGB_W-1:0] rd_data,
  output lane_ctl_t        ctl,
  output emit_t            emit
);

  logic [RGB_W-1:0] mem [MEM_DEPTH];

  state_t state, state_next;

  logic [ROW_W-1:0]  in_row, cur_row, row_i, row_hi;
  logic [COL_W-1:0]  in_col, cur_col, col_j, col_lo, col_hi;
  logic [SLOT_W-1:0] in_slot, cur_slot;
  logic [WIN_W-1:0]  kk, ll;
  logic [3:0]        pass;
  logic [BIT_W-1:0]  dcnt;
  smp_tag_t          tag, tag_next;

  logic [WIN_W-1:0]  ctr, d, k_sel, l_sel;
  logic              accept, row_ok, col_ok, wrap_c, wrap_r, win_end, pass_done;
  logic              at_bot, at_right, none, last_px;
  logic [ROW_W-1:0]  r_eff;
  logic [COL_W-1:0]  c_eff;
  logic [SLOT_W-1:0] slot_eff, slot_inc, dsl, slot;
  logic [WD_W-1:0]   col_inc;
  logic [HT_W-1:0]   row_inc;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic signed [XY_W-1:0] hm1, wm1, rs, cs, r_m, c_m, row_lo_v, col_lo_v, row_hi_v;
  logic signed [XY_W-1:0] col_hi_v, y_raw, x_raw, y, x, dif;

  assign ctr = (cfg.win - WIN_W'(1)) >> 1;
  assign d   = cfg.win >> 1;

  // position of the incoming pixel, restarted when beyond a changed size
  always_comb begin
    accept   = in_valid && in_ready;
    row_ok   = {1'b0, in_row} < cfg.height;
    col_ok   = {1'b0, in_col} < cfg.width;
    r_eff    = row_ok ? in_row : '0;
    slot_eff = row_ok ? in_slot : '0;
    c_eff    = col_ok ? in_col : '0;
    col_inc  = {1'b0, c_eff} + WD_W'(1);
    row_inc  = {1'b0, r_eff} + HT_W'(1);
    wrap_c   = col_inc >= cfg.width;
    wrap_r   = row_inc >= cfg.height;
    slot_inc = (slot_eff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_eff + SLOT_W'(1);
    wr_addr  = ADDR_W'(slot_eff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_eff);
  end

  // range of results released by the current pixel
  always_comb begin
    hm1      = XY_W'(cfg.height) - XY_W'(1);
    wm1      = XY_W'(cfg.width) - XY_W'(1);
    rs       = XY_W'(cur_row);
    cs       = XY_W'(cur_col);
    r_m      = rs - XY_W'(d);
    c_m      = cs - XY_W'(d);
    at_bot   = (rs == hm1);
    at_right = (cs == wm1);
    row_lo_v = r_m[XY_W-1] ? '0 : r_m;
    col_lo_v = c_m[XY_W-1] ? '0 : c_m;
    row_hi_v = at_bot ? hm1 : r_m;
    col_hi_v = at_right ? wm1 : c_m;
    none     = (r_m[XY_W-1] && !at_bot) || (c_m[XY_W-1] && !at_right);
  end

  // window element address with edge clamping
  always_comb begin
    k_sel = (state == ST_CENTRE) ? ctr : kk;
    l_sel = (state == ST_CENTRE) ? ctr : ll;
    y_raw = XY_W'(row_i) + XY_W'(k_sel) - XY_W'(ctr);
    x_raw = XY_W'(col_j) + XY_W'(l_sel) - XY_W'(ctr);
    y = y_raw;
    if (y_raw[XY_W-1]) y = '0;
    else if (y_raw > hm1) y = hm1;
    x = x_raw;
    if (x_raw[XY_W-1]) x = '0;
    else if (x_raw > wm1) x = wm1;
    dif  = rs - y;
    dsl  = dif[SLOT_W-1:0];
    slot = (cur_slot >= dsl) ? (cur_slot - dsl) : (cur_slot + SLOT_W'(MAX_WINDOW) - dsl);
    rd_addr = ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x[COL_W-1:0]);
  end

  assign win_end   = (kk == cfg.win - WIN_W'(1)) && (ll == cfg.win - WIN_W'(1));
  assign pass_done = ((pass == 4'd0) && (cfg.mode != MODE_MEDIAN)) || (pass == 4'd8);
  assign last_px   = (row_i == row_hi) && (col_j == col_hi);

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_addr] <= in_pix;
    end
    rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SETUP;
      ST_SETUP:  state_next = none ? ST_IDLE : ST_CENTRE;
      ST_CENTRE: state_next = ST_PASS;
      ST_PASS:   if (win_end && pass_done) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_DLOAD;
      ST_DLOAD:  state_next = ST_DIV;
      ST_DIV:    if (dcnt == '0) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = last_px ? ST_IDLE : ST_CENTRE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = (state == ST_IDLE);
    tag_next        = '0;
    tag_next.is_ctr = (state == ST_CENTRE);
    tag_next.smp    = (state == ST_CENTRE) || (state == ST_PASS);
    tag_next.first  = (state == ST_PASS) && (kk == '0) && (ll == '0);
    tag_next.last   = (state == ST_PASS) && win_end;
    tag_next.stats  = (state == ST_PASS) && (pass == 4'd0);
    tag_next.bitpos = BIT_W'(4'd8 - pass);
    ctl.tag         = tag;
    ctl.div_ld      = (state == ST_DLOAD);
    ctl.div_step    = (state == ST_DIV);
    ctl.dbit        = dcnt;
    emit.load       = (state == ST_EMIT) && out_free;
    emit.row        = row_i;
    emit.col        = col_j;
    emit.last       = last_px;
    emit.eof        = (row_i == ROW_W'(cfg.height - HT_W'(1))) &&
                      (col_j == COL_W'(cfg.width - WD_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tag     <= '0;
      in_row  <= '0;
      in_col  <= '0;
      in_slot <= '0;
    end else begin
      state <= state_next;
      tag   <= tag_next;
      if (accept) begin
        if (wrap_c) begin
          in_col  <= '0;
          in_row  <= wrap_r ? '0 : row_inc[ROW_W-1:0];
          in_slot <= wrap_r ? '0 : slot_inc;
        end else begin
          in_col  <= col_inc[COL_W-1:0];
          in_row  <= r_eff;
          in_slot <= slot_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_row  <= r_eff;
      cur_col  <= c_eff;
      cur_slot <= slot_eff;
    end
    unique case (state)
      ST_SETUP: begin
        row_i  <= row_lo_v[ROW_W-1:0];
        col_j  <= col_lo_v[COL_W-1:0];
        row_hi <= row_hi_v[ROW_W-1:0];
        col_lo <= col_lo_v[COL_W-1:0];
        col_hi <= col_hi_v[COL_W-1:0];
      end
      ST_CENTRE: begin
        kk   <= '0;
        ll   <= '0;
        pass <= '0;
      end
      ST_PASS: begin
        if (win_end) begin
          kk   <= '0;
          ll   <= '0;
          pass <= pass + 4'd1;
        end else if (ll == cfg.win - WIN_W'(1)) begin
          ll <= '0;
          kk <= kk + WIN_W'(1);
        end else begin
          ll <= ll + WIN_W'(1);
        end
      end
      ST_DLOAD: dcnt <= BIT_W'(PIX_W - 1);
      ST_DIV:   dcnt <= dcnt - BIT_W'(1);
      ST_EMIT: begin
        if (out_free && !last_px) begin
          if (col_j == col_hi) begin
            col_j <= col_lo;
            row_i <= row_i + ROW_W'(1);
          end else begin
            col_j <= col_j + COL_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/rgb_rank_order_window_filter_unit.sv */
// Each input pixel is written to the line store in its accept cycle and releases
// 0 to (w/2+1)^2 filtered pixels; one pixel is accepted at a time.
// Results of a pixel are produced one after another by the window walk, which
// for median also runs one walk per result bit. An input releasing no result
// goes from setup straight back to idle. Synchronous reset restores the
// register defaults and the raster position; the line store is not cleared.
// ----------------------------------------------------------------------------
// rgb_rank_order_window_filter_unit
// Rank-order window filter over an RGB raster stream with edge clamping.
// ----------------------------------------------------------------------------
`include "rgb_rank_order_window_filter_unit_defines.svh"

module rgb_rank_order_window_filter_unit import rrof_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [RGB_W-1:0]       s_tdata,   // red, green, blue
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // out_red, out_green, out_blue, out_row, out_column
  output logic                   m_tlast,   // last_of_run
  output logic                   m_tuser,   // end_of_frame
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [2:0]            mode_r;
  logic [2:0]            win_r;
  logic [PIX_W-1:0]      thr_r;
  logic [CFG_DATA_W-1:0] wid_r, hgt_r;

  cfg_t             cfg;
  lane_ctl_t        ctl;
  emit_t            emit;
  logic [RGB_W-1:0] rd_data;
  logic [PIX_W-1:0] res [CH_N];
  logic [OUT_DATA_W-1:0] out_q;
  logic             out_last, out_eof;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= MODE_MIN;
      win_r  <= 3'd3;
      thr_r  <= '0;
      wid_r  <= CFG_DATA_W'(MAX_WIDTH);
      hgt_r  <= CFG_DATA_W'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:      mode_r <= cfg_data[2:0];
        CFG_WINDOW:    win_r  <= cfg_data[2:0];
        CFG_THRESHOLD: thr_r  <= cfg_data[PIX_W-1:0];
        CFG_WIDTH:     wid_r  <= cfg_data;
        CFG_HEIGHT:    hgt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate sizes to the supported range
  always_comb begin
    cfg.mode = mode_r;
    cfg.thr  = thr_r;
    if (int'(win_r) < 2) cfg.win = WIN_W'(2);
    else if (int'(win_r) > MAX_WINDOW) cfg.win = WIN_W'(MAX_WINDOW);
    else cfg.win = WIN_W'(win_r);
    if (wid_r == '0) cfg.width = WD_W'(1);
    else if (int'(wid_r) > MAX_WIDTH) cfg.width = WD_W'(MAX_WIDTH);
    else cfg.width = WD_W'(wid_r);
    if (hgt_r == '0) cfg.height = HT_W'(1);
    else if (int'(hgt_r) > MAX_HEIGHT) cfg.height = HT_W'(MAX_HEIGHT);
    else cfg.height = HT_W'(hgt_r);
    cfg.n = CNT_W'(cfg.win) * CNT_W'(cfg.win);
  end

  rrof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_pix   (s_tdata),
    .out_free (!m_tvalid || m_tready),
    .rd_data  (rd_data),
    .ctl      (ctl),
    .emit     (emit)
  );

  for (genvar ch = 0; ch < CH_N; ch++) begin : g_lane
    rrof_lane u_lane (
      .clk (clk),
      .cfg (cfg),
      .ctl (ctl),
      .pix (rd_data[ch*PIX_W +: PIX_W]),
      .res (res[ch])
    );
  end

  // merge the lanes into the output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_q    <= {emit.col, emit.row, res[2], res[1], res[0]};
      out_last <= emit.last;
      out_eof  <= emit.eof;
    end
  end

  assign m_tdata = OUT_TDATA_W'(out_q);
  assign m_tlast = out_last;
  assign m_tuser = out_eof;

  `RROF_ASSERT_NOW(a_eof_ends_run, m_tvalid && m_tuser, m_tlast,
    "end of frame beat is not the last of its run")
  `RROF_ASSERT_NOW(a_eof_column, m_tvalid && m_tuser,
    out_q[OUT_DATA_W-1 -: COL_W] == COL_W'(cfg.width - WD_W'(1)),
    "end of frame beat not in the last column")
  `RROF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready,
    "input taken while a pixel is still being processed")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams small RGB frames through the rank-order window filter under many
// register settings, predicts every filtered pixel, and checks each output
// beat in order, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import rrof_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    int         gap;
  } pixel_in_t;

  typedef struct {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             eof;
  } pixel_out_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [RGB_W-1:0]       s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rgb_rank_order_window_filter_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pixel_in_t  pixel_feed_q[$];
  pixel_out_t filtered_q[$];
  int         mismatch_count = 0;
  int         fed_count = 0;
  bit         no_gaps = 0;
  bit         no_stalls = 0;
  int         rx_hold = 0;
  int         rx_wait = 0;
  int         tx_gap = 0;
  bit         s_fire;
  bit         m_fire;

  // predictor state
  logic [RGB_W-1:0] line_mem [MAX_WINDOW*MAX_WIDTH];
  int               pos_row, pos_col;
  logic [2:0]       p_mode;
  logic [2:0]       p_win;
  logic [7:0]       p_thr;
  logic [10:0]      p_width;
  logic [10:0]      p_height;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [RGB_W-1:0] mem_at(int y, int x);
    return line_mem[(y % MAX_WINDOW) * MAX_WIDTH + x];
  endfunction

  function automatic logic [7:0] rank_reduce(int vals[49], int n, int centre);
    int v[49];
    int t, a, b, sum, mean, dev;
    v = vals;
    sum = 0;
    for (a = 1; a < n; a++) begin
      t = v[a];
      b = a - 1;
      while (b >= 0 && v[b] > t) begin
        v[b+1] = v[b];
        b--;
      end
      v[b+1] = t;
    end
    for (a = 0; a < n; a++) sum += v[a];
    mean = sum / n;
    dev = (mean > centre) ? mean - centre : centre - mean;
    case (p_mode)
      MODE_MIN:    return v[0];
      MODE_MAX:    return v[n-1];
      MODE_MEDIAN: return (n % 2 == 0) ? (v[n/2] + v[n/2-1]) / 2 : v[n/2];
      MODE_MEAN:   return mean;
      MODE_CLEAN:  return (dev > p_thr) ? mean : centre;
      default:     return centre;
    endcase
  endfunction

  // store one pixel and queue every filtered pixel it completes
  function automatic void filter_accept(logic [RGB_W-1:0] px);
    int w, wd, ht, ctr, d, rlo, rhi, clo, chi, i, j, k, l, y, x, n, ch, cnt;
    int vals[3][49];
    logic [RGB_W-1:0] p, centre;
    logic [7:0] res[3];
    pixel_out_t o;
    w   = clip(p_win, 2, MAX_WINDOW);
    wd  = clip(p_width, 1, MAX_WIDTH);
    ht  = clip(p_height, 1, MAX_HEIGHT);
    ctr = (w % 2) ? w / 2 : w / 2 - 1;
    d   = w - 1 - ctr;
    cnt = 0;
    if (pos_col >= wd) pos_col = 0;
    if (pos_row >= ht) pos_row = 0;
    line_mem[(pos_row % MAX_WINDOW) * MAX_WIDTH + pos_col] = {px[7:0], px[15:8], px[23:16]};
    rlo = (pos_row - d < 0) ? 0 : pos_row - d;
    rhi = (pos_row == ht - 1) ? ht - 1 : pos_row - d;
    clo = (pos_col - d < 0) ? 0 : pos_col - d;
    chi = (pos_col == wd - 1) ? wd - 1 : pos_col - d;
    for (i = rlo; i <= rhi; i++) begin
      for (j = clo; j <= chi; j++) begin
        centre = mem_at(i, j);
        n = 0;
        for (k = 0; k < w; k++) begin
          for (l = 0; l < w; l++) begin
            y = clip(i + k - ctr, 0, ht - 1);
            x = clip(j + l - ctr, 0, wd - 1);
            p = mem_at(y, x);
            vals[0][n] = p[23:16];
            vals[1][n] = p[15:8];
            vals[2][n] = p[7:0];
            n++;
          end
        end
        for (ch = 0; ch < 3; ch++)
          res[ch] = rank_reduce(vals[ch], n, centre[23-8*ch -: 8]);
        o.red = res[0];
        o.green = res[1];
        o.blue = res[2];
        o.row = i;
        o.col = j;
        o.last = 0;
        o.eof = (i == ht - 1 && j == wd - 1);
        filtered_q = {filtered_q, o};
        cnt++;
      end
    end
    if (cnt > 0) filtered_q[$].last = 1;
    pos_col++;
    if (pos_col >= wd) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= ht) pos_row = 0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // monitor
  always @(posedge clk) begin
    pixel_out_t e;
    s_fire = !rst && s_tvalid && s_tready;
    m_fire = !rst && m_tvalid && m_tready;
    if (s_fire) filter_accept(s_tdata);
    if (m_fire) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", m_tdata));
      end else begin
        e = filtered_q.pop_front();
        if (m_tdata[7:0] !== e.red)
          report_mismatch($sformatf("red %h exp %h", m_tdata[7:0], e.red));
        if (m_tdata[15:8] !== e.green)
          report_mismatch($sformatf("green %h exp %h", m_tdata[15:8], e.green));
        if (m_tdata[23:16] !== e.blue)
          report_mismatch($sformatf("blue %h exp %h", m_tdata[23:16], e.blue));
        if (m_tdata[33:24] !== e.row)
          report_mismatch($sformatf("row %0d exp %0d", m_tdata[33:24], e.row));
        if (m_tdata[43:34] !== e.col)
          report_mismatch($sformatf("column %0d exp %0d", m_tdata[43:34], e.col));
        if (m_tlast !== e.last)
          report_mismatch($sformatf("last %b exp %b", m_tlast, e.last));
        if (m_tuser !== e.eof)
          report_mismatch($sformatf("end of frame %b exp %b", m_tuser, e.eof));
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    pixel_in_t it;
    if (rst) begin
      s_tvalid <= 0;
    end else if (s_tvalid && !s_fire) begin
      // hold the beat
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      s_tvalid <= 0;
    end else if (pixel_feed_q.size() != 0) begin
      it = pixel_feed_q.pop_front();
      s_tdata <= {it.blue, it.green, it.red};
      s_tvalid <= 1;
      tx_gap <= it.gap;
    end else begin
      s_tvalid <= 0;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    int wv;
    if (rst) begin
      m_tready <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= 0;
    end else if (m_fire || !m_tready) begin
      wv = no_stalls ? 0 : $urandom_range(0, 10);
      if (m_fire && wv > 0) begin
        m_tready <= 0;
        rx_wait <= wv - 1;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic cfg_write(cfg_idx_e idx, int value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:      p_mode = value;
      CFG_WINDOW:    p_win = value;
      CFG_THRESHOLD: p_thr = value;
      CFG_WIDTH:     p_width = value;
      CFG_HEIGHT:    p_height = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic setup(int mode, int win, int thr, int wd, int ht);
    cfg_write(CFG_MODE, mode);
    cfg_write(CFG_WINDOW, win);
    cfg_write(CFG_THRESHOLD, thr);
    cfg_write(CFG_WIDTH, wd);
    cfg_write(CFG_HEIGHT, ht);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic push_frame(int npix, bit extremes);
    pixel_in_t it;
    for (int q = 0; q < npix; q++) begin
      it.red = extremes ? ((q % 2) ? 8'hFF : 8'h00) : rand_chan();
      it.green = extremes ? ((q % 3 == 0) ? 8'hFF : 8'h00) : rand_chan();
      it.blue = extremes ? ((q == 1) ? 8'h00 : 8'hFF) : rand_chan();
      it.gap = no_gaps ? 0 : $urandom_range(0, 10);
      pixel_feed_q = {pixel_feed_q, it};
    end
    fed_count += npix;
  endtask

  task automatic drain();
    while (pixel_feed_q.size() != 0 || s_tvalid || filtered_q.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int wd, ht, phase;
    foreach (line_mem[a]) line_mem[a] = '0;
    pos_row = 0;
    pos_col = 0;
    p_mode = MODE_MIN;
    p_win = 3;
    p_thr = 0;
    p_width = 1024;
    p_height = 1024;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    m_tready = 0;
    cfg_valid = 0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: every mode on 2x2 frames of extreme values, then odd sizes
    for (int m = MODE_MIN; m <= MODE_CLEAN; m++) begin
      setup(m, (m == MODE_MEDIAN) ? 7 : 2, (m == MODE_CLEAN) ? 255 : 0, 2, 2);
      push_frame(4, 1);
      drain();
    end
    setup(7, 0, 0, 0, 0);
    push_frame(1, 1);
    drain();
    setup(MODE_CLEAN, 1, 0, 2047, 1);
    push_frame(0, 1);
    setup(MODE_CLEAN, 1, 0, 1, 2047 & 3);
    push_frame(3, 1);
    drain();

    phase = 0;
    while (fed_count < 262) begin
      wd = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
      ht = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      no_gaps = ($urandom_range(0, 3) == 0) || phase == 3;
      no_stalls = ($urandom_range(0, 3) == 0);
      setup($urandom_range(0, 7), $urandom_range(0, 7),
            ($urandom_range(0, 2) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255),
            wd, ht);
      if (phase == 3) rx_hold = 3000;
      push_frame(((wd == 0) ? 1 : wd) * ((ht == 0) ? 1 : ht), 0);
      drain();
      phase++;
    end

    if (mismatch_count == 0 && filtered_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

endmodule
